### rtl/fdcd_pkg.sv
// Shared types and constants for the framed drive command decoder.
`timescale 1ns / 1ps

package fdcd_pkg;

   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] STOP_BYTE  = 8'hFE;

   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_IDLE  = 4'd0;
   localparam logic [POS_W-1:0] POS_SERVO = 4'd1;
   localparam logic [POS_W-1:0] POS_STOP  = 4'd8;

   localparam int BYTE_W      = 8;
   localparam int AXIS_W      = 9;
   localparam int DB_LOW_W    = 9;
   localparam int DB_HIGH_W   = 10;
   localparam int SCALE_W     = 12;
   localparam int SERVO_W     = 12;
   localparam int DIR_W       = 4;
   localparam int PRODUCT_W   = BYTE_W + SCALE_W;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND_LOW     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND_HIGH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVO_FULL_SCALE = 2'd2;

   localparam logic [DB_LOW_W-1:0]  DEADBAND_LOW_RESET     = 9'd490;
   localparam logic [DB_HIGH_W-1:0] DEADBAND_HIGH_RESET    = 10'd530;
   localparam logic [SCALE_W-1:0]   SERVO_FULL_SCALE_RESET = 12'd2500;

   // floor(p / 253) == (p * ceil(2^28 / 253)) >> 28 for every p below 2^20
   localparam int RECIP_W      = 21;
   localparam int RECIP_SHIFT  = 28;
   localparam int SCALED_W     = PRODUCT_W + RECIP_W;
   localparam int QUOT_W       = SCALED_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] SERVO_RECIP = 21'd1061010;
   localparam logic [SERVO_W-1:0] SERVO_MAX   = 12'd4095;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [3:0] {
      KIND_IDLE,
      KIND_SERVO,
      KIND_AXIS_FIRST,
      KIND_AXIS_SECOND,
      KIND_DUTY_FWD,
      KIND_DUTY_BWD,
      KIND_DUTY_LEFT,
      KIND_RULES,
      KIND_STOP_OK,
      KIND_STOP_ERR
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [BYTE_W-1:0]      data;
      logic [PRODUCT_W-1:0]   product;
   } cmd_type;

endpackage

### rtl/framed_drive_command_decoder.sv
// Top level of the framed drive command decoder.
`timescale 1ns / 1ps

// Decodes link bytes framed as 0xFF, seven data bytes, 0xFE into a servo compare
// value, four H-bridge direction bits and two motor duties, with a frame_ok or
// frame_error pulse at the stop position. Every accepted byte yields exactly one
// result item carrying the current outputs. One byte is accepted per cycle while
// the queue is not full; its command passes through the queue into the result
// register, popped one per cycle while it is empty or being taken. The
// front end classifies bytes and forms the servo product, a QUEUE_DEPTH-entry
// queue decouples it from the back end, so input stalls only when the queue is
// full. Configuration registers are written through csr_* with no read-back.

module framed_drive_command_decoder #(
   parameter int QUEUE_DEPTH = fdcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fdcd_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fdcd_pkg::SERVO_W-1:0]       rsp_servo_compare,
   output logic [fdcd_pkg::DIR_W-1:0]         rsp_direction_bits,
   output logic [fdcd_pkg::BYTE_W-1:0]        rsp_duty_a,
   output logic [fdcd_pkg::BYTE_W-1:0]        rsp_duty_b,
   output logic                               rsp_frame_ok,
   output logic                               rsp_frame_error,
   input  logic                               csr_write_enable,
   input  logic [fdcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fdcd_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import fdcd_pkg::*;

   logic [DB_LOW_W-1:0]  deadband_low_ff;
   logic [DB_HIGH_W-1:0] deadband_high_ff;
   logic [SCALE_W-1:0]   servo_full_scale_ff;

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_low_ff     <= DEADBAND_LOW_RESET;
         deadband_high_ff    <= DEADBAND_HIGH_RESET;
         servo_full_scale_ff <= SERVO_FULL_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEADBAND_LOW:     deadband_low_ff     <= csr_write_data[DB_LOW_W-1:0];
            CSR_DEADBAND_HIGH:    deadband_high_ff    <= csr_write_data[DB_HIGH_W-1:0];
            CSR_SERVO_FULL_SCALE: servo_full_scale_ff <= csr_write_data[SCALE_W-1:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   fdcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .servo_full_scale (servo_full_scale_ff),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   fdcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   fdcd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .deadband_low       (deadband_low_ff),
      .deadband_high      (deadband_high_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_servo_compare  (rsp_servo_compare),
      .rsp_direction_bits (rsp_direction_bits),
      .rsp_duty_a         (rsp_duty_a),
      .rsp_duty_b         (rsp_duty_b),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_frame_error    (rsp_frame_error)
   );

   // a stop byte is either good or bad, never both
   a_ok_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_ok && rsp_frame_error))
      else $error("frame_ok and frame_error both set");

   // a taken result with nothing queued must not be shown again
   a_no_duplicate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !head_valid) |=> !rsp_valid)
      else $error("result repeated without a queued item");

   // a queued item moves into a free result register at once
   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !rsp_valid) |=> rsp_valid)
      else $error("back end idle with a queued item");

   // an accepted item with an empty queue and free output is at the queue head in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !head_valid && (!rsp_valid || !rsp_stall)) |=> head_valid)
      else $error("accepted item not queued");

endmodule

### rtl/fdcd_front.sv
// Front end: frame position tracking, byte classification, servo product.
`timescale 1ns / 1ps

module fdcd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fdcd_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [fdcd_pkg::SCALE_W-1:0]   servo_full_scale,
   input  logic                           queue_full,
   output logic                           push_valid,
   output fdcd_pkg::cmd_type              push_cmd
);
   import fdcd_pkg::*;

   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic             accept;
   kind_type         kind;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      position_in = position_ff;
      kind        = KIND_IDLE;
      unique case (position_ff)
         4'd1: begin
            kind        = KIND_SERVO;
            position_in = 4'd2;
         end
         4'd2: begin
            kind        = KIND_AXIS_FIRST;
            position_in = 4'd3;
         end
         4'd3: begin
            kind        = KIND_AXIS_SECOND;
            position_in = 4'd4;
         end
         4'd4: begin
            kind        = KIND_DUTY_FWD;
            position_in = 4'd5;
         end
         4'd5: begin
            kind        = KIND_DUTY_BWD;
            position_in = 4'd6;
         end
         4'd6: begin
            kind        = KIND_DUTY_LEFT;
            position_in = 4'd7;
         end
         4'd7: begin
            kind        = KIND_RULES;
            position_in = POS_STOP;
         end
         POS_STOP: begin
            kind        = (req_rx_byte == STOP_BYTE) ? KIND_STOP_OK : KIND_STOP_ERR;
            position_in = POS_IDLE;
         end
         default: begin
            // idle and unused positions ignore the byte
            kind        = KIND_IDLE;
            position_in = position_ff;
         end
      endcase
      // a start byte is handled at its position first, then restarts the frame
      if (req_rx_byte == START_BYTE) begin
         position_in = POS_SERVO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= POS_IDLE;
      end else if (accept) begin
         position_ff <= position_in;
      end
   end

   always_comb begin
      push_cmd.kind    = kind;
      push_cmd.data    = req_rx_byte;
      push_cmd.product = {{SCALE_W{1'b0}}, req_rx_byte} * {{BYTE_W{1'b0}}, servo_full_scale};
   end

endmodule

### rtl/fdcd_queue.sv
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module fdcd_queue #(
   parameter int DEPTH = fdcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  fdcd_pkg::cmd_type    push_cmd,
   output logic                 full,
   output logic                 head_valid,
   output fdcd_pkg::cmd_type    head_cmd,
   input  logic                 pop
);
   import fdcd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/fdcd_back.sv
// Back end: executes queued commands and holds the result register.
`timescale 1ns / 1ps

module fdcd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  fdcd_pkg::cmd_type               head_cmd,
   output logic                            pop,
   input  logic [fdcd_pkg::DB_LOW_W-1:0]   deadband_low,
   input  logic [fdcd_pkg::DB_HIGH_W-1:0]  deadband_high,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fdcd_pkg::SERVO_W-1:0]    rsp_servo_compare,
   output logic [fdcd_pkg::DIR_W-1:0]      rsp_direction_bits,
   output logic [fdcd_pkg::BYTE_W-1:0]     rsp_duty_a,
   output logic [fdcd_pkg::BYTE_W-1:0]     rsp_duty_b,
   output logic                            rsp_frame_ok,
   output logic                            rsp_frame_error
);
   import fdcd_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SERVO_W-1:0]   servo_ff, servo_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic [BYTE_W-1:0]    duty_a_ff, duty_a_in;
   logic [BYTE_W-1:0]    duty_b_ff, duty_b_in;
   logic                 ok_ff, ok_in;
   logic                 err_ff, err_in;
   logic [AXIS_W-1:0]    axis_first_ff, axis_first_in;
   logic [AXIS_W-1:0]    axis_second_ff, axis_second_in;
   logic [BYTE_W-1:0]    duty_fwd_ff, duty_fwd_in;
   logic [BYTE_W-1:0]    duty_bwd_ff, duty_bwd_in;
   logic [BYTE_W-1:0]    duty_left_ff, duty_left_in;
   logic [SCALED_W-1:0]  scaled;
   logic [QUOT_W-1:0]    quotient;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   assign scaled   = {{RECIP_W{1'b0}}, head_cmd.product} * {{PRODUCT_W{1'b0}}, SERVO_RECIP};
   assign quotient = scaled[SCALED_W-1:RECIP_SHIFT];

   always_comb begin
      logic [DB_HIGH_W-1:0] a;
      logic [DB_HIGH_W-1:0] s;
      logic [DB_HIGH_W-1:0] lo;
      logic [DB_HIGH_W-1:0] hi;
      logic [DIR_W-1:0]     d;
      a  = {1'b0, axis_first_ff};
      s  = {1'b0, axis_second_ff};
      lo = {1'b0, deadband_low};
      hi = deadband_high;
      d  = dir_ff;

      rsp_valid_in   = rsp_valid_ff;
      servo_in       = servo_ff;
      dir_in         = dir_ff;
      duty_a_in      = duty_a_ff;
      duty_b_in      = duty_b_ff;
      ok_in          = ok_ff;
      err_in         = err_ff;
      axis_first_in  = axis_first_ff;
      axis_second_in = axis_second_ff;
      duty_fwd_in    = duty_fwd_ff;
      duty_bwd_in    = duty_bwd_ff;
      duty_left_in   = duty_left_ff;

      if (pop) begin
         rsp_valid_in = 1'b1;
         ok_in        = 1'b0;
         err_in       = 1'b0;
         unique case (head_cmd.kind)
            KIND_SERVO: begin
               servo_in = (quotient > QUOT_W'(SERVO_MAX)) ? SERVO_MAX : quotient[SERVO_W-1:0];
            end
            KIND_AXIS_FIRST:  axis_first_in  = {head_cmd.data, 1'b0};
            KIND_AXIS_SECOND: axis_second_in = {head_cmd.data, 1'b0};
            KIND_DUTY_FWD:    duty_fwd_in    = head_cmd.data;
            KIND_DUTY_BWD:    duty_bwd_in    = head_cmd.data;
            KIND_DUTY_LEFT:   duty_left_in   = head_cmd.data;
            KIND_RULES: begin
               // later rules override earlier ones
               if (a > lo && a < hi) begin
                  d = d | 4'h3;
               end
               if (s > lo && s < hi) begin
                  d = d | 4'hC;
               end
               if (a > hi) begin
                  d         = (d | 4'h5) & ~4'hA;
                  duty_a_in = duty_bwd_ff;
                  duty_b_in = duty_bwd_ff;
               end
               if (a < lo) begin
                  d         = (d | 4'hA) & ~4'h5;
                  duty_a_in = duty_fwd_ff;
                  duty_b_in = duty_fwd_ff;
               end
               if (s < lo) begin
                  d         = (d | 4'h6) & ~4'h9;
                  duty_a_in = head_cmd.data;
                  duty_b_in = head_cmd.data;
               end
               if (s > hi) begin
                  d         = (d | 4'h9) & ~4'h6;
                  duty_a_in = duty_left_ff;
                  duty_b_in = duty_left_ff;
               end
               dir_in = d;
            end
            KIND_STOP_OK:  ok_in  = 1'b1;
            KIND_STOP_ERR: err_in = 1'b1;
            default: begin
               // idle byte: result repeats the current outputs
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         servo_ff     <= '0;
         dir_ff       <= '0;
         duty_a_ff    <= '0;
         duty_b_ff    <= '0;
         ok_ff        <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         servo_ff     <= servo_in;
         dir_ff       <= dir_in;
         duty_a_ff    <= duty_a_in;
         duty_b_ff    <= duty_b_in;
         ok_ff        <= ok_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_first_ff  <= axis_first_in;
      axis_second_ff <= axis_second_in;
      duty_fwd_ff    <= duty_fwd_in;
      duty_bwd_ff    <= duty_bwd_in;
      duty_left_ff   <= duty_left_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_servo_compare  = servo_ff;
   assign rsp_direction_bits = dir_ff;
   assign rsp_duty_a         = duty_a_ff;
   assign rsp_duty_b         = duty_b_ff;
   assign rsp_frame_ok       = ok_ff;
   assign rsp_frame_error    = err_ff;

endmodule

### bench/framed_drive_command_decoder_tb.sv
// Self-checking testbench for the framed drive command decoder.
`timescale 1ns / 1ps

module framed_drive_command_decoder_tb;
   import fdcd_pkg::*;

   localparam int SERVO_DIV     = 253;
   localparam int IDLE_LIMIT    = 4000;
   localparam int LONG_HOLD     = 400;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES        = 7;

   // H-bridge patterns; each drive rule sets its pattern and clears the other bits
   localparam logic [DIR_W-1:0] DIR_BACKWARD = 4'b0101;
   localparam logic [DIR_W-1:0] DIR_FORWARD  = 4'b1010;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 4'b0110;
   localparam logic [DIR_W-1:0] DIR_LEFT     = 4'b1001;
   localparam logic [DIR_W-1:0] DIR_A_BAND   = 4'b0011;
   localparam logic [DIR_W-1:0] DIR_B_BAND   = 4'b1100;

   typedef struct packed {
      logic [SERVO_W-1:0] servo;
      logic [DIR_W-1:0]   dir;
      logic [BYTE_W-1:0]  duty_a;
      logic [BYTE_W-1:0]  duty_b;
      logic               ok;
      logic               err;
   } drive_out_type;

   typedef struct packed {
      logic          typed;
      drive_out_type want;
   } typed_out_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      drive_out_type     want;
   } stim_row_type;

   localparam drive_out_type NO_OUT     = '0;
   localparam drive_out_type SERVO_FULL = '{servo: 12'd2500, default: '0};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SERVO_W-1:0]     rsp_servo_compare;
   logic [DIR_W-1:0]       rsp_direction_bits;
   logic [BYTE_W-1:0]      rsp_duty_a;
   logic [BYTE_W-1:0]      rsp_duty_b;
   logic                   rsp_frame_ok;
   logic                   rsp_frame_error;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // local copy of the decoder state and its registers
   logic [POS_W-1:0]     pos_q       = POS_IDLE;
   logic [AXIS_W-1:0]    axis_a_q    = '0;
   logic [AXIS_W-1:0]    axis_b_q    = '0;
   logic [BYTE_W-1:0]    duty_fwd_q  = '0;
   logic [BYTE_W-1:0]    duty_bwd_q  = '0;
   logic [BYTE_W-1:0]    duty_left_q = '0;
   logic [SERVO_W-1:0]   servo_q     = '0;
   logic [DIR_W-1:0]     dir_q       = '0;
   logic [BYTE_W-1:0]    duty_a_q    = '0;
   logic [BYTE_W-1:0]    duty_b_q    = '0;
   logic [DB_LOW_W-1:0]  cfg_lo      = DEADBAND_LOW_RESET;
   logic [DB_HIGH_W-1:0] cfg_hi      = DEADBAND_HIGH_RESET;
   logic [SCALE_W-1:0]   cfg_scale   = SERVO_FULL_SCALE_RESET;

   drive_out_type expected_q[$];
   typed_out_type typed_q[$];
   int            mismatches = 0;
   int            items_sent = 0;
   int            results_seen = 0;
   int            idle_cycles = 0;
   bit            no_idle = 1'b0;
   bit            long_hold_done = 1'b0;

   stim_row_type directed [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, NO_OUT},        // idle byte straight after reset
      '{STOP_BYTE, 1'b1, NO_OUT},    // stop byte while idle is ignored
      '{START_BYTE, 1'b1, NO_OUT},
      '{8'd253, 1'b1, SERVO_FULL},   // servo exactly at full scale
      '{8'h00, 1'b0, NO_OUT},        // first axis at zero
      '{8'h80, 1'b0, NO_OUT},
      '{8'h10, 1'b0, NO_OUT},
      '{8'h20, 1'b0, NO_OUT},
      '{8'h30, 1'b0, NO_OUT},
      '{8'h40, 1'b0, NO_OUT},        // rules fire, right duty
      '{STOP_BYTE, 1'b0, NO_OUT},    // clean frame end
      '{START_BYTE, 1'b0, NO_OUT},
      '{START_BYTE, 1'b0, NO_OUT},   // servo data 0xFF, then restart
      '{8'h00, 1'b0, NO_OUT},        // servo zero
      '{START_BYTE, 1'b0, NO_OUT},   // first axis 510, then restart
      '{8'h00, 1'b0, NO_OUT},
      '{8'hF5, 1'b0, NO_OUT},        // first axis right on the low edge
      '{8'h09, 1'b0, NO_OUT},
      '{8'h01, 1'b0, NO_OUT},
      '{8'h02, 1'b0, NO_OUT},
      '{8'h03, 1'b0, NO_OUT},
      '{8'h07, 1'b0, NO_OUT},
      '{START_BYTE, 1'b0, NO_OUT}    // start byte in stop slot: error and restart
   };

   framed_drive_command_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_servo_compare  (rsp_servo_compare),
      .rsp_direction_bits (rsp_direction_bits),
      .rsp_duty_a         (rsp_duty_a),
      .rsp_duty_b         (rsp_duty_b),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_frame_error    (rsp_frame_error),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void steer(input logic [DIR_W-1:0] pattern, input logic [BYTE_W-1:0] duty);
      dir_q    = pattern;
      duty_a_q = duty;
      duty_b_q = duty;
   endfunction

   // advances the local decoder by one byte and returns the outputs it shows
   function automatic drive_out_type decode_link_byte(input logic [BYTE_W-1:0] rx);
      drive_out_type o;
      int unsigned   quot;
      o = '0;
      case (pos_q)
         POS_SERVO: begin
            quot    = (32'(rx) * 32'(cfg_scale)) / SERVO_DIV;
            servo_q = (quot > SERVO_MAX) ? SERVO_MAX : quot[SERVO_W-1:0];
         end
         4'd2: axis_a_q = {rx, 1'b0};
         4'd3: axis_b_q = {rx, 1'b0};
         4'd4: duty_fwd_q = rx;
         4'd5: duty_bwd_q = rx;
         4'd6: duty_left_q = rx;
         4'd7: begin
            // later rules win
            if (axis_a_q > cfg_lo && axis_a_q < cfg_hi) dir_q |= DIR_A_BAND;
            if (axis_b_q > cfg_lo && axis_b_q < cfg_hi) dir_q |= DIR_B_BAND;
            if (axis_a_q > cfg_hi) steer(DIR_BACKWARD, duty_bwd_q);
            if (axis_a_q < cfg_lo) steer(DIR_FORWARD, duty_fwd_q);
            if (axis_b_q < cfg_lo) steer(DIR_RIGHT, rx);
            if (axis_b_q > cfg_hi) steer(DIR_LEFT, duty_left_q);
         end
         POS_STOP: begin
            o.ok  = (rx == STOP_BYTE);
            o.err = (rx != STOP_BYTE);
         end
         default: ;
      endcase
      if (pos_q == POS_STOP)
         pos_q = POS_IDLE;
      else if (pos_q != POS_IDLE && pos_q < POS_STOP)
         pos_q = pos_q + 1'b1;
      if (rx == START_BYTE)
         pos_q = POS_SERVO;
      o.servo  = servo_q;
      o.dir    = dir_q;
      o.duty_a = duty_a_q;
      o.duty_b = duty_b_q;
      return o;
   endfunction

   // axis bytes land near the dead-band edges half of the time
   function automatic logic [BYTE_W-1:0] pick_axis_byte();
      int v;
      case ($urandom_range(0, 3))
         1:       v = int'(cfg_lo >> 1) - 1 + int'($urandom_range(0, 2));
         2:       v = int'(cfg_hi >> 1) - 1 + int'($urandom_range(0, 2));
         default: v = int'($urandom_range(0, 255));
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[BYTE_W-1:0];
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic typed,
                            input drive_out_type want);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, 15));
      typed_q.push_back('{typed, want});
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
   endtask

   task automatic set_config(input logic [DB_LOW_W-1:0] lo, input logic [DB_HIGH_W-1:0] hi,
                             input logic [SCALE_W-1:0] scale);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEADBAND_LOW;
      csr_write_data   <= CSR_DATA_W'(lo);
      @(posedge clock);
      csr_index      <= CSR_DEADBAND_HIGH;
      csr_write_data <= CSR_DATA_W'(hi);
      @(posedge clock);
      csr_index      <= CSR_SERVO_FULL_SCALE;
      csr_write_data <= CSR_DATA_W'(scale);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_lo    = lo;
      cfg_hi    = hi;
      cfg_scale = scale;
   endtask

   // result side: random hold-offs, plus one long one so the input backs up
   initial begin
      int hold;
      forever begin
         hold = no_idle ? 0 : int'($urandom_range(0, 15));
         if (!long_hold_done && results_seen >= 200) begin
            hold = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (reset || rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      typed_out_type tag;
      drive_out_type calc;
      drive_out_type got;
      drive_out_type want;
      logic          took_in;
      logic          took_out;
      took_in  = !reset && req_valid === 1'b1 && req_stall === 1'b0;
      took_out = !reset && rsp_valid === 1'b1 && rsp_stall === 1'b0;
      if (took_in) begin
         tag  = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
         calc = decode_link_byte(req_rx_byte);
         expected_q.push_back(tag.typed ? tag.want : calc);
      end
      if (took_out) begin
         results_seen++;
         got = '{rsp_servo_compare, rsp_direction_bits, rsp_duty_a, rsp_duty_b,
                 rsp_frame_ok, rsp_frame_error};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output item: servo %0d dir %b duty_a %0d duty_b %0d",
                        got.servo, got.dir, got.duty_a, got.duty_b);
         end else begin
            want = expected_q.pop_front();
            if (got.servo !== want.servo || got.dir !== want.dir ||
                got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
                got.ok !== want.ok || got.err !== want.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("item %0d: exp %0d %b %0d/%0d ok %b err %b, got %0d %b %0d/%0d ok %b err %b",
                           results_seen, want.servo, want.dir, want.duty_a, want.duty_b,
                           want.ok, want.err, got.servo, got.dir, got.duty_a, got.duty_b,
                           got.ok, got.err);
            end
         end
      end
      if (took_in || took_out || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int phase_end;
      logic [BYTE_W-1:0] rx;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_byte(directed[i].rx, directed[i].typed, directed[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         // let the last accepted item reach the expected queue, then wait until it drains
         @(posedge clock);
         while (expected_q.size() != 0) @(posedge clock);
         repeat (2) @(posedge clock);
         case (phase)
            0: set_config(DEADBAND_LOW_RESET, DEADBAND_HIGH_RESET, SERVO_FULL_SCALE_RESET);
            1: set_config('0, '0, '0);
            2: set_config(9'd511, 10'd1023, 12'd4095);
            3: set_config(9'd511, 10'd0, 12'd4095);          // inverted dead band
            4: set_config(9'd100, 10'd900, SCALE_W'($urandom_range(0, 4095)));
            5: set_config(DB_LOW_W'($urandom_range(0, 511)), DB_HIGH_W'($urandom_range(0, 1023)),
                          SCALE_W'($urandom_range(0, 4095)));
            default: set_config(9'd256, 10'd300, 12'd4095);
         endcase
         phase_end = items_sent + 85;
         while (items_sent < phase_end) begin
            no_idle = (phase == 2) || ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 8) begin
               send_byte(START_BYTE, 1'b0, NO_OUT);
               // servo byte leans toward the saturation corner
               rx = ($urandom_range(0, 3) == 0) ? 8'(252 + $urandom_range(0, 3))
                                                : 8'($urandom_range(0, 254));
               send_byte(rx, 1'b0, NO_OUT);
               send_byte(pick_axis_byte(), 1'b0, NO_OUT);
               send_byte(pick_axis_byte(), 1'b0, NO_OUT);
               repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_OUT);
               rx = ($urandom_range(0, 6) != 0) ? STOP_BYTE : 8'($urandom_range(0, 255));
               send_byte(rx, 1'b0, NO_OUT);
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_OUT);
            end
         end
      end

      no_idle = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
